// File: hdl/cela_pkg.sv
// Package: shared constants, types and the natural log table entry function for the loss accumulator
`default_nettype none
package cela_pkg;
    localparam int LOG_TABLE_ENTRIES = 256;
    localparam int ACC_BITS          = 48;
    localparam logic [15:0] ONE_Q15  = 16'd32768;
    localparam logic [23:0] LN2_Q16  = 24'd45426;
    localparam int OUT_BITS          = 48;
    localparam int QUEUE_DEPTH       = 4;

    typedef enum logic {
        t_cfg_clip  = 1'b0,
        t_cfg_batch = 1'b1
    } t_cfg_index;

    // Work item handed from the front end to the back end
    typedef struct packed {
        logic [15:0] p;     // clamped prediction
        logic [15:0] y;     // clamped label
        logic        last;
    } t_item;

    typedef enum logic [1:0] {
        t_st_idle = 2'd0,
        t_st_log  = 2'd1,
        t_st_div  = 2'd2,
        t_st_out  = 2'd3
    } t_state;

    // Restoring long division on constants; elaboration time only
    function automatic longint unsigned div_u64(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned quo, rem;
        quo = 0;
        rem = 0;
        for (int j = 63; j >= 0; j--) begin
            rem = (rem << 1) | ((a >> j) & 64'd1);
            quo = quo << 1;
            if (rem >= b) begin
                rem = rem - b;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // round(65536 * ln(1 + i/n)) through a Q.30 atanh series; elaboration time only
    function automatic logic [23:0] ln_entry(input longint unsigned i, input longint unsigned n);
        longint unsigned z, z2, pw, sum;
        z = div_u64(i << 30, 2 * n + i);
        z2 = (z * z) >> 30;
        pw = z;
        sum = 0;
        for (int k = 0; k < 24; k++) begin
            sum = sum + div_u64(pw, 64'(2 * k + 1));
            pw = (pw * z2) >> 30;
        end
        return 24'((2 * sum + (64'd1 << 13)) >> 14);
    endfunction
endpackage
`default_nettype wire

// File: hdl/cross_entropy_loss_accumulator.sv
// Top level: binary cross-entropy loss accumulator
//
//  channel   | dir | handshake             | payload
//  s_axis    | in  | tvalid/tready         | tdata {label, prediction}, tlast = last
//  m_axis    | out | tvalid/tready         | tdata loss_value, tuser = saturated
//  cfg       | in  | i_cfg_we              | i_cfg_index, i_cfg_data
//
// In the back end each item is taken from the queue, then goes through two
// table-and-interpolate passes (prediction and its complement), a step that registers
// the second log and a step for the weighted add. A last item then adds bit-serial
// division and a step that loads the result. The front queue holds four clamped
// requests, so the input side keeps taking items while the back end is busy or the
// result waits, until the queue is full. Reset is synchronous, active low.
`default_nettype none
module cross_entropy_loss_accumulator #(
    parameter int LOG_TABLE_ENTRIES = cela_pkg::LOG_TABLE_ENTRIES,
    parameter int ACC_BITS          = cela_pkg::ACC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] prediction, [31:16] label
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [47:0] loss_value
    output logic             m_axis_tuser    // [0] saturated
);
    logic [13:0] r_clip;
    logic [15:0] r_batch;
    logic item_valid, item_take;
    cela_pkg::t_item item;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= 14'd1; r_batch <= 16'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == cela_pkg::t_cfg_clip) r_clip  <= i_cfg_data[13:0];
            else                                    r_batch <= i_cfg_data;
        end
    end

    cela_front u_front (
        .i_clk, .i_rst_n, .i_clip(r_clip),
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .o_item_valid(item_valid), .i_item_take(item_take), .o_item(item)
    );

    cela_back #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES), .ACC_BITS(ACC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_batch(r_batch),
        .i_item_valid(item_valid), .o_item_take(item_take), .i_item(item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_loss(m_axis_tdata), .o_sat(m_axis_tuser)
    );
endmodule
`default_nettype wire

// File: hdl/cela_front.sv
// Front end: clamp items and queue them for the back end
`default_nettype none
module cela_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [13:0]           i_clip,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [31:0]           s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    output logic                       o_item_valid,
    input  wire logic                  i_item_take,
    output cela_pkg::t_item            o_item
);
    localparam int PW = $clog2(cela_pkg::QUEUE_DEPTH);
    cela_pkg::t_item r_q [cela_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic [15:0]   th, hi, p, y;
    logic          push, pop;

    always_comb begin
        th = (i_clip == 14'd0) ? 16'd1 : {2'b00, i_clip};
        hi = cela_pkg::ONE_Q15 - th;
        p  = s_axis_tdata[15:0];
        if (p < th) p = th;
        if (p > hi) p = hi;
        y  = (s_axis_tdata[31:16] > cela_pkg::ONE_Q15) ? cela_pkg::ONE_Q15 : s_axis_tdata[31:16];
    end

    assign s_axis_tready = (r_cnt != (PW+1)'(cela_pkg::QUEUE_DEPTH));
    assign push = s_axis_tvalid && s_axis_tready;
    assign o_item_valid = (r_cnt != '0);
    assign pop = o_item_valid && i_item_take;
    assign o_item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= '{p: p, y: y, last: s_axis_tlast};
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// File: hdl/cela_back.sv
// Back end: log lookups, accumulation, division and result register
`default_nettype none
module cela_back #(
    parameter int LOG_TABLE_ENTRIES = cela_pkg::LOG_TABLE_ENTRIES,
    parameter int ACC_BITS          = cela_pkg::ACC_BITS
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [15:0]     i_batch,
    input  wire logic            i_item_valid,
    output logic                 o_item_take,
    input  wire cela_pkg::t_item i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [47:0]          o_loss,
    output logic                 o_sat
);
    localparam int IW = $clog2(LOG_TABLE_ENTRIES);
    localparam int AW = ACC_BITS;
    localparam logic [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic [AW-1:0] OUT_MAX = AW'({1'b0, {47{1'b1}}});
    localparam int DCW = $clog2(AW + 1);

    // constant log table, with ln 2 as the closing entry
    logic [23:0] ln_tab [LOG_TABLE_ENTRIES+1];
    for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_tab
        localparam logic [23:0] ENT = (g == LOG_TABLE_ENTRIES) ? cela_pkg::LN2_Q16 :
            cela_pkg::ln_entry(64'(g), 64'(LOG_TABLE_ENTRIES));
        assign ln_tab[g] = ENT;
    end

    cela_pkg::t_state r_st, n_st;
    cela_pkg::t_item  r_it;
    logic        r_ph;              // 0: log of p, 1: log of 1-p
    logic [23:0] r_lo, r_hi;        // stage 1: table pair
    logic [14:0] r_r;
    logic [3:0]  r_sh;
    logic        r_s1;              // stage-1 contents valid
    logic        r_s1_ph;
    logic        r_s2;              // both logs registered
    logic [19:0] r_nl_p;            // -ln p, Q.16
    logic [19:0] r_nl_q;            // -ln (1-p), Q.16
    logic [AW-1:0] r_sum, r_rem, r_quo;
    logic        r_ovf;
    logic [DCW-1:0] r_dc;
    logic [47:0] r_loss;
    logic        r_sat, r_ov;

    // normalise q and form the table index
    logic [15:0] q;
    logic [3:0]  k;
    logic [14:0] f;
    logic [IW+14:0] sc;
    logic [IW-1:0] idx;
    always_comb begin
        q = r_ph ? (cela_pkg::ONE_Q15 - r_it.p) : r_it.p;
        k = 4'd0;
        for (int b = 1; b < 15; b++) if (q[b]) k = 4'(b);
        f  = 15'(q << (4'd15 - k));
        sc = (IW+15)'(f) * (IW+15)'(LOG_TABLE_ENTRIES);
        idx = sc[IW+14:15];
    end

    logic signed [24:0] dlt;
    logic [39:0] mul;
    logic [23:0] lnm;
    logic [19:0] nl;
    always_comb begin
        dlt = $signed({1'b0, r_hi}) - $signed({1'b0, r_lo});
        mul = 40'(dlt * $signed({1'b0, r_r}));
        lnm = r_lo + 24'(mul[39:15]);
        nl  = 20'(24'(r_sh) * cela_pkg::LN2_Q16 - lnm);
    end

    logic [36:0] term;
    logic [AW-1:0] sum_c, t_ext;
    always_comb begin
        term = (37'(r_it.y) * 37'(r_nl_p) + 37'(17'(cela_pkg::ONE_Q15) - 17'(r_it.y)) * 37'(r_nl_q)
                + 37'd16384) >> 15;
        t_ext = AW'(term);
        sum_c = (r_sum > ACC_MAX) ? ACC_MAX : r_sum;
    end

    logic [AW-1:0] bs, rem_sh;
    assign bs = (i_batch == 16'd0) ? AW'(1) : AW'(i_batch);
    assign rem_sh = {r_rem[AW-2:0], r_quo[AW-1]};

    assign o_item_take = (r_st == cela_pkg::t_st_idle) && i_item_valid;
    assign o_valid = r_ov;
    assign o_loss  = r_loss;
    assign o_sat   = r_sat;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            cela_pkg::t_st_idle: if (i_item_valid) n_st = cela_pkg::t_st_log;
            cela_pkg::t_st_log:  if (r_s2)
                                     n_st = r_it.last ? cela_pkg::t_st_div : cela_pkg::t_st_idle;
            cela_pkg::t_st_div:  if (r_dc == '0) n_st = cela_pkg::t_st_out;
            cela_pkg::t_st_out:  if (!r_ov || i_ready) n_st = cela_pkg::t_st_idle;
            default:             n_st = cela_pkg::t_st_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_it <= i_item; r_ph <= 1'b0;
        end
        if (r_st == cela_pkg::t_st_log) begin
            r_lo <= ln_tab[{1'b0, idx}];
            r_hi <= ln_tab[{1'b0, idx} + 1'b1];
            r_r  <= sc[14:0];
            r_sh <= 4'd15 - k;
            r_s1_ph <= r_ph;
            if (!r_s1) r_ph <= 1'b1;
            if (r_s1 && !r_s1_ph) r_nl_p <= nl;
            if (r_s1 && r_s1_ph)  r_nl_q <= nl;
        end
        if (r_st == cela_pkg::t_st_div) begin
            if (r_dc == DCW'(AW)) begin
                r_quo <= r_sum; r_rem <= '0;
            end else if (rem_sh >= bs) begin
                r_rem <= rem_sh - bs; r_quo <= {r_quo[AW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;      r_quo <= {r_quo[AW-2:0], 1'b0};
            end
        end
        if (!i_rst_n) begin
            r_st <= cela_pkg::t_st_idle; r_s1 <= 1'b0; r_s2 <= 1'b0; r_sum <= '0;
            r_ovf <= 1'b0; r_ov <= 1'b0; r_dc <= '0;
        end else begin
            r_st <= n_st;
            r_s1 <= (r_st == cela_pkg::t_st_log) && !(r_s1 && r_s1_ph) && !r_s2;
            r_s2 <= (r_st == cela_pkg::t_st_log) && r_s1 && r_s1_ph;
            if (r_st == cela_pkg::t_st_log && r_s2) begin
                if (t_ext > ACC_MAX - sum_c) begin
                    r_sum <= ACC_MAX; r_ovf <= 1'b1;
                end else begin
                    r_sum <= sum_c + t_ext;
                end
                r_dc <= DCW'(AW);
            end
            if (r_st == cela_pkg::t_st_div && r_dc != '0) r_dc <= r_dc - 1'b1;
            if (r_st == cela_pkg::t_st_out && (!r_ov || i_ready)) begin
                r_ov   <= 1'b1;
                r_loss <= (r_quo > OUT_MAX) ? 48'(OUT_MAX) : 48'(r_quo);
                r_sat  <= r_ovf || (r_quo > OUT_MAX);
                r_sum  <= '0;
                r_ovf  <= 1'b0;
            end else if (i_ready) begin
                r_ov   <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// File: verif/cela_checker.sv
// Checker: watches the stream and configuration ports, predicts the mean loss and compares
`timescale 1ns / 100ps
`default_nettype none
module cela_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [15:0] prediction, [31:16] label
    input  wire logic        i_s_tlast,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [47:0] i_m_tdata,   // [47:0] loss_value
    input  wire logic        i_m_tuser,   // [0] saturated
    output int               o_errors,
    output int               o_pending
);
    typedef struct {
        logic [47:0] loss;
        logic        sat;
    } t_mean_loss;

    localparam longint unsigned LN2 = 45426;
    localparam longint unsigned SUM_MAX = (64'd1 << 47) - 1;

    t_mean_loss      mean_q[$];
    longint unsigned ln_tab[cela_pkg::LOG_TABLE_ENTRIES];
    longint unsigned run_sum;
    logic            run_ovf;
    logic [13:0]     clip_reg;
    logic [15:0]     batch_reg;

    // Build ln(1 + i/n) in Q.16 from a Q.30 atanh series, rounded half up
    function automatic longint unsigned ln_frac(longint unsigned i, longint unsigned n);
        longint unsigned z, z2, pw, acc;
        z = (i << 30) / (2 * n + i);
        z2 = (z * z) >> 30;
        pw = z;
        acc = 0;
        for (int k = 0; k < 24; k++) begin
            acc += pw / (2 * k + 1);
            pw = (pw * z2) >> 30;
        end
        return ((2 * acc + (64'd1 << 13)) >> 14) & 64'hFFFFFF;
    endfunction

    // -ln(q / 32768) in Q.16 for q in [1, 32767]
    function automatic longint unsigned neg_log(longint unsigned q);
        int              k;
        longint unsigned f, scaled, idx, r, lo, hi, lnm;
        k = 14;
        while (k > 0 && q[k] == 1'b0) k--;
        f = ((q << (15 - k)) - 32768) & 32767;
        scaled = f * cela_pkg::LOG_TABLE_ENTRIES;
        idx = (scaled >> 15) % cela_pkg::LOG_TABLE_ENTRIES;
        r = scaled & 32767;
        lo = ln_tab[idx];
        hi = (idx + 1 < cela_pkg::LOG_TABLE_ENTRIES) ? ln_tab[idx + 1] : LN2;
        lnm = lo + ((((hi - lo) & 64'hFFFFFFFF) * r) >> 15);
        return (15 - k) * LN2 - lnm;
    endfunction

    initial begin
        for (int i = 0; i < cela_pkg::LOG_TABLE_ENTRIES; i++)
            ln_tab[i] = ln_frac(i, cela_pkg::LOG_TABLE_ENTRIES);
    end

    // Add one item's loss to the running sum; push the mean on the last item
    task automatic add_item(longint unsigned p, longint unsigned y, logic last);
        longint unsigned th, term, bs, quot;
        t_mean_loss      m;
        th = (clip_reg == 0) ? 1 : clip_reg;
        if (p < th) p = th;
        if (p > 32768 - th) p = 32768 - th;
        if (y > 32768) y = 32768;
        term = (y * neg_log(p) + (32768 - y) * neg_log(32768 - p) + 16384) >> 15;
        if (term > SUM_MAX - run_sum) begin
            run_sum = SUM_MAX;
            run_ovf = 1'b1;
        end else begin
            run_sum += term;
        end
        if (last) begin
            bs = (batch_reg == 0) ? 1 : batch_reg;
            quot = run_sum / bs;
            m.sat = run_ovf;
            if (quot > SUM_MAX) begin
                quot = SUM_MAX;
                m.sat = 1'b1;
            end
            m.loss = quot[47:0];
            mean_q.push_back(m);
            run_sum = 0;
            run_ovf = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_mean_loss exp_m;
        if (!i_rst_n) begin
            clip_reg = 14'd1;
            batch_reg = 16'd1;
            run_sum = 0;
            run_ovf = 1'b0;
            mean_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == cela_pkg::t_cfg_clip) clip_reg = i_cfg_data[13:0];
                else batch_reg = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready)
                add_item(i_s_tdata[15:0], i_s_tdata[31:16], i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (mean_q.size() == 0) begin
                    $error("unexpected result: loss_value %0d", $signed(i_m_tdata));
                    o_errors++;
                end else begin
                    exp_m = mean_q.pop_front();
                    if (i_m_tdata !== exp_m.loss) begin
                        $error("loss_value: expected %0d, got %0d", exp_m.loss, i_m_tdata);
                        o_errors++;
                    end
                    if (i_m_tuser !== exp_m.sat) begin
                        $error("saturated: expected %0b, got %0b", exp_m.sat, i_m_tuser);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = mean_q.size();
    end
endmodule
`default_nettype wire

// File: verif/tb_cross_entropy_loss_accumulator.sv
// Testbench top: clock, reset, stimulus and verdict for the loss accumulator
`timescale 1ns / 100ps
`default_nettype none
module tb_cross_entropy_loss_accumulator;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [15:0] prediction, [31:16] label
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [47:0] loss_value
    logic        m_axis_tuser;   // [0] saturated
    int          errors;
    int          pending;
    logic        no_idle;        // hold both sides busy while set

    cross_entropy_loss_accumulator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    cela_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tuser(m_axis_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: stall at random with a chance of 17 in 100, never while no_idle is set
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= no_idle || ($urandom_range(99) >= 17);
    end

    // Offer one request and hold it until the block takes it; maybe idle first
    task automatic send_pair(logic [15:0] pred, logic [15:0] lab, logic last);
        if (!no_idle && $urandom_range(99) < 17) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lab, pred};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid, wait for every expected mean, then let the back end settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(cela_pkg::t_cfg_index idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Probabilities: mostly in range, some hugging the edges, some above one
    function automatic logic [15:0] rand_q15();
        case ($urandom_range(9))
            0:       return 16'($urandom_range(65535));
            1:       return 16'($urandom_range(40));
            2:       return 16'($urandom_range(32768, 32728));
            3:       return 16'($urandom_range(1) ? 0 : 32768);
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    // One stream of random pairs closed by a last request
    task automatic send_stream(int len);
        for (int i = 0; i < len; i++) send_pair(rand_q15(), rand_q15(), i == len - 1);
    endtask

    initial begin
        int len;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= cela_pkg::t_cfg_clip;
        i_cfg_data    <= 16'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 32'd0;
        s_axis_tlast  <= 1'b0;
        no_idle       = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: zero and one on both fields, label and prediction above one
        send_pair(16'd0, 16'd0, 1'b0);
        send_pair(16'd32768, 16'd32768, 1'b0);
        send_pair(16'hFFFF, 16'hFFFF, 1'b0);
        send_pair(16'd1, 16'd0, 1'b0);
        send_pair(16'd32767, 16'd32768, 1'b1);
        send_pair(16'd16384, 16'd16384, 1'b1);
        drain();

        // Zero threshold and zero batch size both act as one
        write_reg(cela_pkg::t_cfg_clip, 16'hC000);
        write_reg(cela_pkg::t_cfg_batch, 16'd0);
        send_pair(16'd0, 16'd32768, 1'b0);
        send_pair(16'd32768, 16'd0, 1'b0);
        send_pair(16'd5, 16'hFFFF, 1'b1);
        drain();

        // Widest clamp and largest divisor
        write_reg(cela_pkg::t_cfg_clip, 16'h3FFF);
        write_reg(cela_pkg::t_cfg_batch, 16'hFFFF);
        send_pair(16'd0, 16'd0, 1'b0);
        send_pair(16'hFFFF, 16'd12345, 1'b0);
        send_pair(16'd16383, 16'd32768, 1'b1);
        drain();

        // Random phases: fresh settings, then streams mostly short
        for (int ph = 0; ph < 14; ph++) begin
            case (ph % 4)
                0: write_reg(cela_pkg::t_cfg_clip, 16'd1);
                1: write_reg(cela_pkg::t_cfg_clip, 16'h3FFF);
                default: write_reg(cela_pkg::t_cfg_clip, 16'($urandom_range(65535)));
            endcase
            case (ph % 5)
                0: write_reg(cela_pkg::t_cfg_batch, 16'd1);
                1: write_reg(cela_pkg::t_cfg_batch, 16'hFFFF);
                2: write_reg(cela_pkg::t_cfg_batch, 16'd0);
                default: write_reg(cela_pkg::t_cfg_batch, 16'($urandom_range(65535)));
            endcase
            no_idle = (ph == 6 || ph == 7);
            for (int s = 0; s < 12; s++) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
                send_stream(len);
            end
            drain();
        end
        no_idle = 1'b0;

        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hdl/cela_pkg.sv
hdl/cela_front.sv
hdl/cela_back.sv
hdl/cross_entropy_loss_accumulator.sv
verif/cela_checker.sv
verif/tb_cross_entropy_loss_accumulator.sv
